@@ sv/tdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tdfs_pkg
// Shared types, constants and helpers for the tube digit fade sequencer.
// ----------------------------------------------------------------------------
package tdfs_pkg;

    // tube counts: TUBE_COUNT tubes in the engine, IO_TUBES digits on the ports
    localparam int TUBE_COUNT = 6;
    localparam int IO_TUBES   = 6;

    localparam int DIGIT_W = 4;
    localparam int LEVEL_W = 8;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [1:0]         mode_t;

    localparam level_t FULL_LEVEL      = '1;
    localparam level_t FADE_STEP_RESET = level_t'(15);

    // item kinds
    localparam mode_t MODE_DIGITS  = 2'd0;
    localparam mode_t MODE_TICK    = 2'd1;
    localparam mode_t MODE_RESTART = 2'd2;

    // configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_FADE_ENABLE = 1'b0;
    localparam cfg_index_t CFG_FADE_STEP   = 1'b1;
    localparam int CFG_DATA_W = LEVEL_W;

    // input transaction
    typedef struct packed {
        mode_t  mode;
        digit_t new_0;
        digit_t new_1;
        digit_t new_2;
        digit_t new_3;
        digit_t new_4;
        digit_t new_5;
    } tdfs_in_t;

    // result transaction
    typedef struct packed {
        digit_t shown_0;
        digit_t shown_1;
        digit_t shown_2;
        digit_t shown_3;
        digit_t shown_4;
        digit_t shown_5;
        level_t level_0;
        level_t level_1;
        level_t level_2;
        level_t level_3;
        level_t level_4;
        level_t level_5;
    } tdfs_out_t;

    // per-tube update commands, applied in priority settle, take_instant, take_fade, tick
    typedef struct packed {
        logic   settle;
        logic   take_instant;
        logic   take_fade;
        logic   tick;
        level_t step;
    } tdfs_ctl_t;

    // digit of tube idx from an input transaction, 0 for tubes with no field
    function automatic digit_t in_digit(tdfs_in_t item, int idx);
        digit_t d;
        case (idx)
            0:       d = item.new_0;
            1:       d = item.new_1;
            2:       d = item.new_2;
            3:       d = item.new_3;
            4:       d = item.new_4;
            5:       d = item.new_5;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

@@ sv/tdfs_tube.sv @@
// ----------------------------------------------------------------------------
// tdfs_tube
// State of one tube: shown, previous and pending digits, fade phase, level.
// ----------------------------------------------------------------------------
module tdfs_tube
    import tdfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  tdfs_ctl_t ctl,
    input  digit_t    incoming,
    output digit_t    shown,
    output level_t    level
);

    typedef enum logic [1:0] {
        PH_STABLE = 2'd0,
        PH_OUT    = 2'd1,
        PH_IN     = 2'd2
    } phase_t;

    phase_t phase_reg,    phase_next;
    level_t level_reg,    level_next;
    digit_t shown_reg,    shown_next;
    digit_t previous_reg, previous_next;
    digit_t pending_reg,  pending_next;

    // next state for the highest-priority active command
    always_comb begin
        phase_next    = phase_reg;
        level_next    = level_reg;
        shown_next    = shown_reg;
        previous_next = previous_reg;
        pending_next  = pending_reg;
        if (ctl.settle) begin
            phase_next   = PH_STABLE;
            level_next   = FULL_LEVEL;
            pending_next = '0;
        end else if (ctl.take_instant) begin
            shown_next    = incoming;
            previous_next = incoming;
        end else if (ctl.take_fade) begin
            previous_next = incoming;
            if (incoming != previous_reg) begin
                pending_next = incoming;
                if (phase_reg == PH_STABLE) begin
                    phase_next = PH_OUT;
                end
            end
        end else if (ctl.tick) begin
            case (phase_reg)
                PH_OUT: begin
                    if (level_reg <= ctl.step) begin
                        level_next = '0;
                        shown_next = pending_reg;
                        phase_next = PH_IN;
                    end else begin
                        level_next = level_reg - ctl.step;
                    end
                end
                PH_IN: begin
                    if (level_reg >= FULL_LEVEL - ctl.step) begin
                        level_next = FULL_LEVEL;
                        phase_next = PH_STABLE;
                    end else begin
                        level_next = level_reg + ctl.step;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // tube state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_STABLE;
            level_reg    <= FULL_LEVEL;
            shown_reg    <= '0;
            previous_reg <= '0;
            pending_reg  <= '0;
        end else begin
            phase_reg    <= phase_next;
            level_reg    <= level_next;
            shown_reg    <= shown_next;
            previous_reg <= previous_next;
            pending_reg  <= pending_next;
        end
    end

    assign shown = shown_reg;
    assign level = level_reg;

endmodule

@@ sv/tube_digit_fade_sequencer.sv @@
// ----------------------------------------------------------------------------
// tube_digit_fade_sequencer
// Six-tube digit cross-fade engine: new digits, frame ticks and restarts.
// ----------------------------------------------------------------------------
// path from input transaction to result valid: input register, then tube state
//   update, whose registers drive the result directly
// throughput: one transaction per cycle while the result side keeps up
// reset: aresetn synchronous active low; tubes stable at level 255, digits 0,
//   fading off, fade step 15, no previous digits
module tube_digit_fade_sequencer
    import tdfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tdfs_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tdfs_out_t             m_data,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic      in_valid_reg;
    tdfs_in_t  in_data_reg;
    logic      m_valid_reg;
    logic      fade_enable_reg;
    level_t    fade_step_reg;
    logic      previous_valid_reg;
    logic      advance;
    tdfs_ctl_t ctl;
    digit_t    shown_arr [IO_TUBES];
    level_t    level_arr [IO_TUBES];

    // the held transaction updates the tubes once the result slot is free
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // result valid, the tube state itself is the result payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // configuration and previous-digits flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_enable_reg    <= 1'b0;
            fade_step_reg      <= FADE_STEP_RESET;
            previous_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FADE_ENABLE: fade_enable_reg <= cfg_data[0];
                    CFG_FADE_STEP:   fade_step_reg   <= cfg_data[LEVEL_W-1:0];
                    default:         fade_step_reg   <= fade_step_reg;
                endcase
            end
            if (advance && in_data_reg.mode == MODE_DIGITS) begin
                previous_valid_reg <= 1'b1;
            end else if (advance && in_data_reg.mode == MODE_RESTART) begin
                previous_valid_reg <= 1'b0;
            end
        end
    end

    // tube commands
    always_comb begin
        ctl.settle       = (cfg_we && cfg_index == CFG_FADE_ENABLE && !cfg_data[0])
                           || (advance && in_data_reg.mode == MODE_RESTART);
        ctl.take_instant = advance && in_data_reg.mode == MODE_DIGITS
                           && (!fade_enable_reg || !previous_valid_reg);
        ctl.take_fade    = advance && in_data_reg.mode == MODE_DIGITS
                           && fade_enable_reg && previous_valid_reg;
        ctl.tick         = advance && in_data_reg.mode == MODE_TICK && fade_enable_reg;
        ctl.step         = fade_step_reg;
    end

    // tube array
    generate
        for (genvar i = 0; i < TUBE_COUNT; i++) begin : g_tube
            digit_t t_shown;
            level_t t_level;
            tdfs_tube u_tube (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .incoming (in_digit(in_data_reg, i)),
                .shown    (t_shown),
                .level    (t_level)
            );
            if (i < IO_TUBES) begin : g_io
                assign shown_arr[i] = t_shown;
                assign level_arr[i] = t_level;
            end
        end
        for (genvar j = TUBE_COUNT; j < IO_TUBES; j++) begin : g_absent
            assign shown_arr[j] = '0;
            assign level_arr[j] = FULL_LEVEL;
        end
    endgenerate

    // result payload
    assign m_valid         = m_valid_reg;
    assign m_data.shown_0  = shown_arr[0];
    assign m_data.shown_1  = shown_arr[1];
    assign m_data.shown_2  = shown_arr[2];
    assign m_data.shown_3  = shown_arr[3];
    assign m_data.shown_4  = shown_arr[4];
    assign m_data.shown_5  = shown_arr[5];
    assign m_data.level_0  = level_arr[0];
    assign m_data.level_1  = level_arr[1];
    assign m_data.level_2  = level_arr[2];
    assign m_data.level_3  = level_arr[3];
    assign m_data.level_4  = level_arr[4];
    assign m_data.level_5  = level_arr[5];

endmodule

@@ sim/tube_digit_fade_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// tube_digit_fade_sequencer_tb
// Self-checking bench for the six-tube digit fade engine. A short scripted
// sequence covers instant changes, digit codes above nine, the unused item
// kind, restarts, digits arriving mid fade and fade steps 0, 1, 254 and 255.
// Random phases with varying fade settings follow. Every result is checked
// field by field against a cycle-free model of the tube state, with random
// idle cycles and one long result stall.
// ----------------------------------------------------------------------------
module tube_digit_fade_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tdfs_pkg::*;

    localparam mode_t MODE_RESERVED = 2'd3;
    localparam int DIGITS_W = TUBE_COUNT * DIGIT_W;
    localparam int LEVELS_W = TUBE_COUNT * LEVEL_W;
    localparam logic [LEVELS_W-1:0] ALL_FULL = {TUBE_COUNT{FULL_LEVEL}};
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 80;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {
        PH_STABLE   = 2'd0,
        PH_FADE_OUT = 2'd1,
        PH_FADE_IN  = 2'd2
    } tube_phase_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        tdfs_in_t              item;
        logic                  typed;
        tdfs_out_t             want;
        cfg_index_t            reg_idx;
        logic [CFG_DATA_W-1:0] reg_value;
    } script_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tdfs_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    tdfs_out_t             m_data;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tube_digit_fade_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model of the tube state and settings
    logic        fade_on;
    level_t      fade_step_r;
    digit_t      shown_q   [TUBE_COUNT];
    digit_t      last_digit[TUBE_COUNT];
    logic        last_known;
    tube_phase_t phase_q   [TUBE_COUNT];
    level_t      level_q   [TUBE_COUNT];
    digit_t      pending_q [TUBE_COUNT];

    tdfs_out_t   display_q[$];
    script_row_t script[$];

    int   errors       = 0;
    int   results_seen = 0;
    int   items_sent   = 0;
    int   ticks_sent   = 0;
    int   digit_sets   = 0;
    int   restarts     = 0;
    logic no_gaps      = 1'b0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2ms;
        $display("tube_digit_fade_sequencer_tb failed");
        $finish;
    end

    // all tubes back to stable at full level, pending digits cleared
    function automatic void settle_all();
        int i;
        for (i = 0; i < TUBE_COUNT; i++) begin
            phase_q[i]   = PH_STABLE;
            level_q[i]   = FULL_LEVEL;
            pending_q[i] = '0;
        end
    endfunction

    // apply one transaction to the model and return the display it leaves
    function automatic tdfs_out_t predict_display(tdfs_in_t item);
        mode_t                m;
        logic [DIGITS_W-1:0]  dg;
        logic [DIGITS_W-1:0]  sh;
        logic [LEVELS_W-1:0]  lv;
        digit_t               incoming;
        int                   i;
        {m, dg} = item;
        case (m)
            MODE_DIGITS: begin
                for (i = 0; i < TUBE_COUNT; i++) begin
                    incoming = dg[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W];
                    if (!fade_on || !last_known) begin
                        shown_q[i] = incoming;
                    end else if (incoming != last_digit[i]) begin
                        pending_q[i] = incoming;
                        // a tube already fading keeps its current fade
                        if (phase_q[i] != PH_FADE_OUT && phase_q[i] != PH_FADE_IN)
                            phase_q[i] = PH_FADE_OUT;
                    end
                    last_digit[i] = incoming;
                end
                last_known = 1'b1;
            end
            MODE_TICK: begin
                if (fade_on) begin
                    for (i = 0; i < TUBE_COUNT; i++) begin
                        if (phase_q[i] == PH_FADE_OUT) begin
                            if (level_q[i] <= fade_step_r) begin
                                level_q[i] = '0;
                                shown_q[i] = pending_q[i];
                                phase_q[i] = PH_FADE_IN;
                            end else begin
                                level_q[i] = level_q[i] - fade_step_r;
                            end
                        end else if (phase_q[i] == PH_FADE_IN) begin
                            if (int'(level_q[i]) >= int'(FULL_LEVEL) - int'(fade_step_r)) begin
                                level_q[i] = FULL_LEVEL;
                                phase_q[i] = PH_STABLE;
                            end else begin
                                level_q[i] = level_q[i] + fade_step_r;
                            end
                        end
                    end
                end
            end
            MODE_RESTART: begin
                settle_all();
                last_known = 1'b0;
            end
            default: ;
        endcase
        for (i = 0; i < TUBE_COUNT; i++) begin
            sh[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W] = shown_q[i];
            lv[(TUBE_COUNT-1-i)*LEVEL_W +: LEVEL_W] = level_q[i];
        end
        return {sh, lv};
    endfunction

    // scripted rows
    function automatic void add_item(mode_t m, logic [DIGITS_W-1:0] dg);
        script_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.item = {m, dg};
        script.push_back(row);
    endfunction

    function automatic void add_checked(mode_t m, logic [DIGITS_W-1:0] dg,
                                        logic [DIGITS_W-1:0] sh,
                                        logic [LEVELS_W-1:0] lv);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.item  = {m, dg};
        row.typed = 1'b1;
        row.want  = {sh, lv};
        script.push_back(row);
    endfunction

    function automatic void add_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        script_row_t row;
        row           = '0;
        row.kind      = ROW_WRITE;
        row.reg_idx   = idx;
        row.reg_value = value;
        script.push_back(row);
    endfunction

    function automatic digit_t random_digit();
        if ($urandom_range(7) == 0)
            return digit_t'($urandom_range(15, 10));
        return digit_t'($urandom_range(9));
    endfunction

    // compare one result transaction with the oldest expected display
    task automatic check_display(tdfs_out_t got);
        tdfs_out_t           want;
        logic [DIGITS_W-1:0] got_sh, want_sh;
        logic [LEVELS_W-1:0] got_lv, want_lv;
        int                  i;
        if (display_q.size() == 0) begin
            $error("result transaction with no display expected: %h", got);
            errors++;
            return;
        end
        want = display_q.pop_front();
        {got_sh, got_lv}   = got;
        {want_sh, want_lv} = want;
        for (i = 0; i < TUBE_COUNT; i++) begin
            if (got_sh[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W] !==
                want_sh[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W]) begin
                $error("shown_%0d: expected %0d, got %0d", i,
                       want_sh[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W],
                       got_sh[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W]);
                errors++;
            end
            if (got_lv[(TUBE_COUNT-1-i)*LEVEL_W +: LEVEL_W] !==
                want_lv[(TUBE_COUNT-1-i)*LEVEL_W +: LEVEL_W]) begin
                $error("level_%0d: expected %0d, got %0d", i,
                       want_lv[(TUBE_COUNT-1-i)*LEVEL_W +: LEVEL_W],
                       got_lv[(TUBE_COUNT-1-i)*LEVEL_W +: LEVEL_W]);
                errors++;
            end
        end
    endtask

    // offer one transaction, called at a falling edge, returns at a falling edge
    task automatic offer_item(tdfs_in_t item, logic typed, tdfs_out_t want);
        tdfs_out_t predicted;
        while (!no_gaps && $urandom_range(99) < 25) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_display(item);
        display_q.push_back(typed ? want : predicted);
        items_sent++;
        case (item.mode)
            MODE_DIGITS:  digit_sets++;
            MODE_TICK:    ticks_sent++;
            MODE_RESTART: restarts++;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // hold the input until every expected display has arrived
    task automatic wait_drained();
        s_valid = 1'b0;
        while (display_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_FADE_ENABLE) begin
            fade_on = value[0];
            if (!fade_on)
                settle_all();
        end else if (idx == CFG_FADE_STEP) begin
            fade_step_r = level_t'(value);
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial begin : result_sink
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_display(m_data);
                results_seen++;
            end
            @(negedge aclk);
            if (!hold_done && results_seen >= 300) begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = no_gaps || ($urandom_range(99) >= 25);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int                  p, k, r, i;
        tdfs_in_t            item;
        logic [DIGITS_W-1:0] dg;
        mode_t               m;
        logic [CFG_DATA_W-1:0] step_pick;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FADE_ENABLE;
        cfg_data  = '0;

        fade_on     = 1'b0;
        fade_step_r = FADE_STEP_RESET;
        last_known  = 1'b0;
        for (i = 0; i < TUBE_COUNT; i++) begin
            shown_q[i]    = '0;
            last_digit[i] = '0;
        end
        settle_all();

        // instant changes with fading off, codes above nine, unused kind
        add_checked(MODE_DIGITS, 24'h909090, 24'h909090, ALL_FULL);
        add_checked(MODE_DIGITS, 24'hFFFFFF, 24'hFFFFFF, ALL_FULL);
        add_checked(MODE_TICK, 24'h000000, 24'hFFFFFF, ALL_FULL);
        add_checked(MODE_RESERVED, 24'h123456, 24'hFFFFFF, ALL_FULL);
        add_checked(MODE_RESTART, 24'h000000, 24'hFFFFFF, ALL_FULL);
        // one-tick fades; first digits after restart show at once
        add_write(CFG_FADE_ENABLE, 8'd1);
        add_write(CFG_FADE_STEP, 8'd255);
        add_checked(MODE_DIGITS, 24'h123456, 24'h123456, ALL_FULL);
        add_item(MODE_DIGITS, 24'h123457);
        add_checked(MODE_TICK, 24'h000000, 24'h123457, {{5{FULL_LEVEL}}, 8'h00});
        // new digit on a tube that is fading in stays pending
        add_item(MODE_DIGITS, 24'h023458);
        add_item(MODE_TICK, 24'h000000);
        add_item(MODE_TICK, 24'h000000);
        add_item(MODE_TICK, 24'h000000);
        // slowest step, then fading switched off mid fade
        add_write(CFG_FADE_STEP, 8'd1);
        add_item(MODE_DIGITS, 24'h999999);
        add_item(MODE_TICK, 24'h000000);
        add_item(MODE_TICK, 24'h000000);
        add_write(CFG_FADE_ENABLE, 8'd0);
        add_item(MODE_TICK, 24'h000000);
        // zero step stalls fades, then step 254
        add_write(CFG_FADE_ENABLE, 8'd1);
        add_write(CFG_FADE_STEP, 8'd0);
        add_item(MODE_DIGITS, 24'h000000);
        add_item(MODE_TICK, 24'h000000);
        add_item(MODE_TICK, 24'h000000);
        add_write(CFG_FADE_STEP, 8'd254);
        add_item(MODE_TICK, 24'h000000);
        add_item(MODE_TICK, 24'h000000);
        add_item(MODE_TICK, 24'h000000);
        add_item(MODE_RESTART, 24'h000000);
        add_item(MODE_DIGITS, 24'h876543);

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // scripted part
        foreach (script[n]) begin
            if (script[n].kind == ROW_WRITE)
                write_reg(script[n].reg_idx, script[n].reg_value);
            else
                offer_item(script[n].item, script[n].typed, script[n].want);
        end

        // random phases, settings changed between them
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       step_pick = 8'd255;
                1:       step_pick = 8'd1;
                3:       step_pick = 8'd254;
                6:       step_pick = 8'd85;
                default: step_pick = CFG_DATA_W'($urandom_range(90, 8));
            endcase
            write_reg(CFG_FADE_STEP, step_pick);
            write_reg(CFG_FADE_ENABLE, (p == 2) ? 8'd0 : 8'd1);
            no_gaps = (p == 4);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                dg = '0;
                if (r < 55)
                    m = MODE_TICK;
                else if (r < 95 && r >= 62)
                    m = MODE_DIGITS;
                else if (r < 62)
                    m = MODE_RESTART;
                else
                    m = (r < 98) ? MODE_RESERVED : MODE_DIGITS;
                // mostly a few tubes change; sometimes every tube is random
                for (i = 0; i < TUBE_COUNT; i++) begin
                    if (r >= 95 || $urandom_range(99) < 35)
                        dg[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W] = random_digit();
                    else
                        dg[(TUBE_COUNT-1-i)*DIGIT_W +: DIGIT_W] = last_digit[i];
                end
                item = {m, dg};
                offer_item(item, 1'b0, '0);
                if ($urandom_range(59) == 0)
                    wait_drained();
            end
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (8) @(negedge aclk);

        $display("sent %0d transactions: %0d digit sets, %0d ticks, %0d restarts; %0d checked",
                 items_sent, digit_sets, ticks_sent, restarts, results_seen);
        $display("fade steps 0, 1, 254, 255 and random, fading on and off, one long stall");
        if (errors == 0) begin
            $display("tube_digit_fade_sequencer_tb passed");
        end else begin
            $display("tube_digit_fade_sequencer_tb failed");
        end
        $finish;
    end

endmodule
